>>> src/xdkn_pkg.sv
// Shared types and constants for the XOR-distance nearest-peer block.
`default_nettype none
package xdkn_pkg;

  // Fixed field widths
  localparam int WORD_W     = 64;
  localparam int DIST_W     = 4 * WORD_W;
  localparam int REF_W      = 16;
  localparam int SLOT_W     = 4;
  localparam int KEPT_W     = 5;
  localparam int LIMIT_W    = 5;
  localparam int IN_TDATA_W = REF_W + DIST_W;   // 272, already whole bytes
  localparam int OUT_TDATA_W = 32;              // 25 bits of fields, zero filled
  localparam int CFG_ADDR_W = 3;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET0 = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET1 = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET2 = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET3 = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_LIMIT   = 3'd4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_REP_RD,
    ST_REP_LD
  } xdkn_state_t;

endpackage
`default_nettype wire

>>> src/xdkn_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none
module xdkn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> src/xor_distance_k_nearest.sv
// Top level: keeps the peers closest to a target ID by XOR distance and reports them.
// Flow: while the table fills, an item is accepted and written in the same cycle.
// Once full, an item is scanned: one distance-RAM read per kept slot, a compare of
// the last read, then a decide/write-back step; no new item is taken until it ends.
// A last item then reports each kept peer by a peer-RAM read and an output load, held
// while the sink stalls; the next item is accepted while the final result waits.
// Reset: control, fill count, target (0) and limit (16) are cleared; RAM contents
// are left undefined and need no clearing pass.
`default_nettype none
module xor_distance_k_nearest #(
  parameter int SLOTS         = 16,
  parameter int PEER_REF_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // in_tdata: peer_ref, id_word0, id_word1, id_word2, id_word3 (lowest bits first)
  input  wire logic [xdkn_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic                              in_tlast,   // last_peer
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // out_tdata: slot_index, near_peer, kept_count, zero fill (lowest bits first)
  output logic [xdkn_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                   out_tlast,  // last_result
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic                              cfg_we,
  input  wire logic [xdkn_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [xdkn_pkg::WORD_W-1:0]       cfg_wdata
);
  import xdkn_pkg::*;

  localparam int AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FW   = $clog2(SLOTS + 1);
  localparam int LW   = (FW > LIMIT_W) ? FW : LIMIT_W;
  localparam int REFW = (PEER_REF_BITS < REF_W) ? PEER_REF_BITS : REF_W;

  // Configuration registers
  logic [WORD_W-1:0]  tgt0_r, tgt1_r, tgt2_r, tgt3_r;
  logic [LIMIT_W-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt0_r  <= '0;
      tgt1_r  <= '0;
      tgt2_r  <= '0;
      tgt3_r  <= '0;
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TARGET0: tgt0_r  <= cfg_wdata;
        REG_TARGET1: tgt1_r  <= cfg_wdata;
        REG_TARGET2: tgt2_r  <= cfg_wdata;
        REG_TARGET3: tgt3_r  <= cfg_wdata;
        REG_LIMIT:   limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Control and payload registers
  xdkn_state_t       state_r, state_nxt;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic [FW-1:0]     scan_r, scan_nxt;
  logic [FW-1:0]     rep_cnt_r, rep_cnt_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]     cmp_idx_r;
  logic [DIST_W-1:0] max_r;
  logic [AW-1:0]     far_r;
  logic [DIST_W-1:0] d_r;
  logic [REFW-1:0]   ref_r;
  logic              last_r;
  logic              out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0] out_slot_r;
  logic [REF_W-1:0]  out_peer_r;
  logic [KEPT_W-1:0] out_kept_r;
  logic              out_last_r;

  // Incoming item: distance is the ID xor target, word0 most significant
  logic [DIST_W-1:0] in_dist;
  logic [REFW-1:0]   in_ref;
  logic              in_acc;
  logic [LW-1:0]     lim_ext, lim_eff;
  logic              store_new;

  assign in_dist = {in_tdata[79:16], in_tdata[143:80], in_tdata[207:144], in_tdata[271:208]}
                 ^ {tgt0_r, tgt1_r, tgt2_r, tgt3_r};
  assign in_ref  = in_tdata[REFW-1:0];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Effective limit saturates to the slot count
  assign lim_ext   = LW'(limit_r);
  assign lim_eff   = (lim_ext > LW'(SLOTS)) ? LW'(SLOTS) : lim_ext;
  assign store_new = LW'(fill_r) < lim_eff;

  // RAM ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DIST_W-1:0] dist_wdata;
  logic [REFW-1:0]   peer_wdata;
  logic              dist_re, peer_re;
  logic [DIST_W-1:0] dist_rdata;
  logic [REFW-1:0]   peer_rdata;
  logic              replace;

  assign replace = (state_r == ST_DECIDE) && (max_r > d_r);

  always_comb begin
    if (state_r == ST_DECIDE) begin
      ram_we     = replace;
      ram_waddr  = far_r;
      dist_wdata = d_r;
      peer_wdata = ref_r;
    end else begin
      ram_we     = in_acc && store_new;
      ram_waddr  = fill_r[AW-1:0];
      dist_wdata = in_dist;
      peer_wdata = in_ref;
    end
  end

  assign dist_re = (state_r == ST_SCAN);
  assign peer_re = (state_r == ST_REP_RD) && (!out_valid_r || out_tready);

  xdkn_ram #(.WIDTH(DIST_W), .DEPTH(SLOTS)) u_dist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (dist_wdata),
    .re    (dist_re),
    .raddr (scan_r[AW-1:0]),
    .rdata (dist_rdata)
  );

  xdkn_ram #(.WIDTH(REFW), .DEPTH(SLOTS)) u_peer_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (peer_wdata),
    .re    (peer_re),
    .raddr (rep_cnt_r[AW-1:0]),
    .rdata (peer_rdata)
  );

  // Next state and control
  logic rep_done;
  assign rep_done = (FW'(rep_cnt_r + 1'b1) == fill_r);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    scan_nxt      = scan_r;
    rep_cnt_nxt   = rep_cnt_r;
    cmp_vld_nxt   = (state_r == ST_SCAN);
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (store_new) begin
            fill_nxt = FW'(fill_r + 1'b1);
            if (in_tlast) begin
              state_nxt = ST_REP_RD;
            end
          end else if (fill_r != '0) begin
            scan_nxt  = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        scan_nxt = FW'(scan_r + 1'b1);
        if (FW'(scan_r + 1'b1) == fill_r) begin
          state_nxt = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_nxt = last_r ? ST_REP_RD : ST_IDLE;
      end
      ST_REP_RD: begin
        if (peer_re) begin
          state_nxt = ST_REP_LD;
        end
      end
      ST_REP_LD: begin
        out_valid_nxt = 1'b1;
        if (rep_done) begin
          fill_nxt    = '0;
          rep_cnt_nxt = '0;
          state_nxt   = ST_IDLE;
        end else begin
          rep_cnt_nxt = FW'(rep_cnt_r + 1'b1);
          state_nxt   = ST_REP_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      scan_r      <= '0;
      rep_cnt_r   <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      scan_r      <= scan_nxt;
      rep_cnt_r   <= rep_cnt_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Latched item and running maximum (strict compare keeps the lowest index on ties)
  always_ff @(posedge clk) begin
    if (in_acc) begin
      d_r    <= in_dist;
      ref_r  <= in_ref;
      last_r <= in_tlast;
    end
    cmp_idx_r <= scan_r[AW-1:0];
    if (cmp_vld_r && ((cmp_idx_r == '0) || (dist_rdata > max_r))) begin
      max_r <= dist_rdata;
      far_r <= cmp_idx_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state_r == ST_REP_LD) begin
      out_slot_r <= SLOT_W'(rep_cnt_r);
      out_peer_r <= REF_W'(peer_rdata);
      out_kept_r <= KEPT_W'(fill_r);
      out_last_r <= rep_done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_TDATA_W - SLOT_W - REF_W - KEPT_W){1'b0}},
                       out_kept_r, out_peer_r, out_slot_r};

  // Checks on the sequencer
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(SLOTS))
    else $error("fill count above slot count");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (fill_r != '0) && (scan_r < fill_r))
    else $error("scan address outside occupied slots");

  a_far_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE) |-> (FW'(far_r) < fill_r))
    else $error("replacement slot outside occupied slots");

  a_rep_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REP_LD && rep_done) |=> (fill_r == '0) && out_valid_r && out_last_r)
    else $error("table not cleared after final report");

  a_ld_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REP_LD) |-> !out_valid_r)
    else $error("output register overwritten while full");

endmodule
`default_nettype wire

>>> tb/sv/xdkn_nearest_monitor.sv
// Channel monitor for the nearest-peer block: tracks the peer table and checks every result item.
`timescale 1ns / 100ps
module xdkn_nearest_monitor #(
  parameter int SLOTS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [xdkn_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tlast,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [xdkn_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                out_tlast,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_we,
  input  logic [xdkn_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [xdkn_pkg::WORD_W-1:0]         cfg_wdata,
  output int                                  errors,
  output int                                  pending
);
  import xdkn_pkg::*;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [REF_W-1:0]  peer;
    logic [KEPT_W-1:0] kept;
    logic              last;
  } near_peer_t;

  // reported peers still owed by the block, oldest first
  near_peer_t        owed_peers_q[$];

  // own copy of registers and peer table
  logic [DIST_W-1:0]  target_id;
  logic [LIMIT_W-1:0] keep_limit;
  logic [DIST_W-1:0]  dist_tab [SLOTS];
  logic [REF_W-1:0]   peer_tab [SLOTS];
  int                 fill;
  int                 err_count = 0;

  assign errors = err_count;

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    err_count++;
    if (err_count <= 40)
      $display("ERROR at %0t ns: %s got %0h expected %0h", $time, what, got, want);
  endtask

  // Offer one peer to the table; on the last peer queue the whole table in slot order
  task automatic rank_peer(logic [REF_W-1:0] handle, logic [DIST_W-1:0] id, logic last);
    int         lim;
    int         far;
    logic [DIST_W-1:0] new_dist;
    near_peer_t rec;
    lim  = (int'(keep_limit) > SLOTS) ? SLOTS : int'(keep_limit);
    new_dist = id ^ target_id;
    if (fill < lim) begin
      dist_tab[fill] = new_dist;
      peer_tab[fill] = handle;
      fill++;
    end else if (fill > 0) begin
      // farthest kept slot, lowest index on ties
      far = 0;
      for (int s = 1; s < fill; s++)
        if (dist_tab[s] > dist_tab[far]) far = s;
      if (dist_tab[far] > new_dist) begin
        dist_tab[far] = new_dist;
        peer_tab[far] = handle;
      end
    end
    if (last) begin
      for (int s = 0; s < fill; s++) begin
        rec.slot = SLOT_W'(s);
        rec.peer = peer_tab[s];
        rec.kept = KEPT_W'(fill);
        rec.last = (s == fill - 1);
        owed_peers_q.push_back(rec);
      end
      fill = 0;
    end
  endtask

  always @(posedge clk) begin
    near_peer_t want;
    if (!rst_n) begin
      target_id  = '0;
      keep_limit = LIMIT_RESET;
      fill       = 0;
      owed_peers_q.delete();
    end else begin
      // result side first: it can only answer older items
      if (out_tvalid && out_tready) begin
        if (owed_peers_q.size() == 0) begin
          report("result item with nothing expected, near_peer", out_tdata[SLOT_W +: REF_W], 0);
        end else begin
          want = owed_peers_q.pop_front();
          if (out_tdata[0 +: SLOT_W] !== want.slot)
            report("slot_index", out_tdata[0 +: SLOT_W], want.slot);
          if (out_tdata[SLOT_W +: REF_W] !== want.peer)
            report("near_peer", out_tdata[SLOT_W +: REF_W], want.peer);
          if (out_tdata[SLOT_W + REF_W +: KEPT_W] !== want.kept)
            report("kept_count", out_tdata[SLOT_W + REF_W +: KEPT_W], want.kept);
          if (out_tlast !== want.last)
            report("last_result", out_tlast, want.last);
        end
      end
      // register writes, unknown indexes dropped
      if (cfg_we) begin
        case (cfg_addr)
          REG_TARGET0: target_id[3*WORD_W +: WORD_W] = cfg_wdata;
          REG_TARGET1: target_id[2*WORD_W +: WORD_W] = cfg_wdata;
          REG_TARGET2: target_id[1*WORD_W +: WORD_W] = cfg_wdata;
          REG_TARGET3: target_id[0*WORD_W +: WORD_W] = cfg_wdata;
          REG_LIMIT:   keep_limit = cfg_wdata[LIMIT_W-1:0];
          default: ;
        endcase
      end
      // input item: word0 of the ID is the most significant
      if (in_tvalid && in_tready)
        rank_peer(in_tdata[0 +: REF_W],
                  {in_tdata[REF_W +: WORD_W], in_tdata[REF_W + WORD_W +: WORD_W],
                   in_tdata[REF_W + 2*WORD_W +: WORD_W], in_tdata[REF_W + 3*WORD_W +: WORD_W]},
                  in_tlast);
    end
    pending <= owed_peers_q.size();
  end

endmodule

>>> tb/sv/tb_xor_distance_k_nearest.sv
// Testbench top for the nearest-peer block: stimulus, flow control, and the final verdict.
`timescale 1ns / 100ps
module tb_xor_distance_k_nearest;
  import xdkn_pkg::*;

  localparam int SLOTS         = 16;
  localparam int SETTLE_CYCLES = 48;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DIRECTED      = 19;
  localparam int RANDOM_ITEMS  = 190;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]   in_tdata = '0;
  logic                    in_tlast = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    out_tlast;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_addr = '0;
  logic [WORD_W-1:0]       cfg_wdata = '0;

  int                      errors;
  int                      pending;
  int                      cycles = 0;
  int                      n_offered = 0;
  bit                      src_calm = 1'b0;
  bit                      sink_calm = 1'b0;
  logic [DIST_W-1:0]       cur_target = '0;

  always #5 clk = ~clk;

  xor_distance_k_nearest #(.SLOTS(SLOTS), .PEER_REF_BITS(REF_W)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tlast(in_tlast), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast), .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  xdkn_nearest_monitor #(.SLOTS(SLOTS)) u_monitor (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tlast(in_tlast), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast), .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Mismatches found");
      $finish;
    end
  end

  // result sink: random stall before each item, with calm stretches
  initial begin
    int stall;
    forever begin
      if ($urandom_range(0, 15) == 0) sink_calm = !sink_calm;
      stall = sink_calm ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(negedge clk);
      while (!out_tvalid) @(negedge clk);
      @(posedge clk);
    end
  end

  function automatic logic [DIST_W-1:0] rand_id();
    return {$urandom(), $urandom(), $urandom(), $urandom(),
            $urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  // ID whose distance to the target has a random number of leading zeros
  function automatic logic [DIST_W-1:0] near_id();
    return cur_target ^ (rand_id() >> $urandom_range(0, DIST_W - 1));
  endfunction

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [WORD_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_target(logic [DIST_W-1:0] t);
    cfg_write(REG_TARGET0, t[3*WORD_W +: WORD_W]);
    cfg_write(REG_TARGET1, t[2*WORD_W +: WORD_W]);
    cfg_write(REG_TARGET2, t[1*WORD_W +: WORD_W]);
    cfg_write(REG_TARGET3, t[0*WORD_W +: WORD_W]);
    cur_target = t;
  endtask

  // Send one peer; returns at the edge that accepted it, tvalid still high
  task automatic offer_peer(logic [REF_W-1:0] handle, logic [DIST_W-1:0] id, logic last);
    int gap;
    if ($urandom_range(0, 15) == 0) src_calm = !src_calm;
    gap = src_calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tlast  <= last;
    in_tdata  <= {id[0 +: WORD_W], id[WORD_W +: WORD_W], id[2*WORD_W +: WORD_W],
                  id[3*WORD_W +: WORD_W], handle};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    n_offered++;
  endtask

  // Drain owed results, then let the block finish any non-reporting item
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [DIST_W-1:0] a_id;
    logic [DIST_W-1:0] id;
    logic [DIST_W-1:0] seen[$];
    logic [WORD_W-1:0] lim_word;
    int                set_len;
    int                mid_at;
    int                r;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: zero target, keep up to 16
    offer_peer('0, '0, 1'b0);
    offer_peer('1, '1, 1'b1);
    settle();

    // keep one: a closer peer replaces, a farther one does not
    set_target('1);
    cfg_write(REG_LIMIT, 1);
    offer_peer(16'h0001, '0, 1'b0);
    offer_peer(16'h0002, '1, 1'b0);
    offer_peer(16'h0003, near_id() ^ 1, 1'b1);
    settle();

    // unused register indexes must be ignored
    for (int a = REG_LIMIT + 1; a < (1 << CFG_ADDR_W); a++)
      cfg_write(CFG_ADDR_W'(a), {$urandom(), $urandom()});

    // keep nothing: the set reports nothing
    cfg_write(REG_LIMIT, 0);
    offer_peer(16'h5A5A, rand_id(), 1'b1);
    settle();

    // limit field above the slot count saturates; upper data bits dropped
    cfg_write(REG_LIMIT, '1);
    set_target(rand_id());
    offer_peer(16'hA5A5, rand_id(), 1'b0);
    offer_peer(16'h00FF, near_id(), 1'b0);
    offer_peer(16'hFF00, rand_id(), 1'b1);
    settle();

    // equal distances: tie on the farthest picks the lowest slot, equal is not replaced
    cfg_write(REG_LIMIT, 2);
    a_id = rand_id();
    offer_peer(16'h1111, a_id, 1'b0);
    offer_peer(16'h2222, a_id, 1'b0);
    offer_peer(16'h3333, cur_target, 1'b0);
    offer_peer(16'h4444, a_id, 1'b1);
    settle();

    // limit dropped below the fill mid-set: slots stay, replacement still works
    cfg_write(REG_LIMIT, 4);
    for (int i = 0; i < 4; i++) offer_peer($urandom_range(0, 65535), rand_id(), 1'b0);
    settle();
    cfg_write(REG_LIMIT, 0);
    offer_peer(16'h7777, cur_target, 1'b0);
    offer_peer(16'h8888, rand_id(), 1'b1);
    settle();

    // random sets
    while (n_offered < DIRECTED + RANDOM_ITEMS) begin
      r = $urandom_range(0, 15);
      if (r < 9)       lim_word = $urandom_range(1, 5);
      else if (r < 12) lim_word = SLOTS;
      else if (r < 13) lim_word = $urandom_range(6, 15);
      else if (r < 14) lim_word = 0;
      else             lim_word = ({$urandom(), $urandom()} & ~64'h1F) | $urandom_range(17, 31);
      cfg_write(REG_LIMIT, lim_word);
      if ($urandom_range(0, 2) == 0) begin
        r = $urandom_range(0, 5);
        set_target(r == 0 ? '0 : (r == 1 ? '1 : rand_id()));
      end
      set_len = $urandom_range(1, 20);
      mid_at  = (set_len >= 4 && $urandom_range(0, 5) == 0) ? set_len / 2 : -1;
      seen.delete();
      for (int i = 0; i < set_len; i++) begin
        if (i == mid_at) begin
          settle();
          cfg_write(REG_LIMIT, $urandom_range(0, 3));
        end
        r = $urandom_range(0, 9);
        if (r < 4)                           id = rand_id();
        else if (r < 7)                      id = near_id();
        else if (r == 7 && seen.size() > 0)  id = seen[$urandom_range(0, seen.size() - 1)];
        else if (r == 8)                     id = cur_target;
        else                                 id = ~cur_target;
        seen.push_back(id);
        offer_peer($urandom_range(0, 65535), id, i == set_len - 1);
      end
      settle();
    end

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> xor_distance_k_nearest.f
src/xdkn_pkg.sv
src/xdkn_ram.sv
src/xor_distance_k_nearest.sv
tb/sv/xdkn_nearest_monitor.sv
tb/sv/tb_xor_distance_k_nearest.sv
